FILE: design/sactd_pkg.sv
package sactd_pkg;
    localparam int NUM_SETS  = 64;
    localparam int WAYS      = 4;
    localparam int ADDR_BITS = 48;
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MAX_SB    = $clog2(NUM_SETS + 1) - 1;
    localparam int NODES     = (WAYS > 1) ? WAYS - 1 : 1;
    localparam int AGE_W     = WAY_W;
    localparam int LINE_W    = ADDR_BITS + 1 + 1 + AGE_W;
    localparam int SETROW_W  = WAYS * LINE_W + NODES;
    localparam int OUT_WAY_W = 2;

    localparam logic [1:0] CFG_OFFSET = 2'd0;
    localparam logic [1:0] CFG_SETB   = 2'd1;
    localparam logic [1:0] CFG_POLICY = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic capture;
        logic out_load;
    } sactd_cmd_t;

    typedef struct packed {
        logic out_busy;
    } sactd_stat_t;
endpackage

FILE: design/sactd_ram.sv
module sactd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: design/sactd_ctrl.sv
module sactd_ctrl import sactd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sactd_stat_t stat,
    output sactd_cmd_t  cmd
);
    typedef enum logic {ST_IDLE, ST_UPD} state_t;
    state_t state_reg;

    // A new transaction enters only when no result is left waiting: the result
    // register is either empty or its result is taken at the same edge.
    assign s_ready      = (state_reg == ST_IDLE) && !stat.out_busy;
    assign cmd.rd_en    = s_valid && s_ready;
    assign cmd.capture  = s_valid && s_ready;
    assign cmd.wr_en    = (state_reg == ST_UPD);
    assign cmd.out_load = (state_reg == ST_UPD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: if (cmd.capture) state_reg <= ST_UPD;
                ST_UPD:  state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: design/sactd_dpath.sv
module sactd_dpath import sactd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [3:0]           cfg_wdata,
    input  logic                 s_cmd,
    input  logic [47:0]          s_addr,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 m_hit,
    output logic [1:0]           m_way,
    output logic                 m_evicted,
    output logic                 m_evicted_dirty,
    output logic [31:0]          m_hit_total,
    output logic [31:0]          m_miss_total,
    output logic [31:0]          m_dirty_evict_total,
    output logic [31:0]          m_clean_evict_total,
    input  sactd_cmd_t           cmd,
    output sactd_stat_t          stat
);
    logic [3:0] offset_bits_reg;
    logic [2:0] set_bits_reg;
    logic       policy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= 4'd6;
            set_bits_reg    <= 3'd6;
            policy_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OFFSET: offset_bits_reg <= cfg_wdata;
                CFG_SETB:   set_bits_reg    <= cfg_wdata[2:0];
                CFG_POLICY: policy_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Address split.
    logic [ADDR_BITS-1:0] addr_m;
    logic [3:0]           sb;
    logic [ADDR_BITS-1:0] tag_in;
    logic [ADDR_BITS-1:0] shifted;
    logic [SET_W-1:0]     set_in;
    logic [ADDR_BITS-1:0] set_mask;

    assign addr_m  = ADDR_BITS'(s_addr);
    assign sb      = ({1'b0, set_bits_reg} > 4'(MAX_SB)) ? 4'(MAX_SB) : {1'b0, set_bits_reg};
    assign tag_in  = addr_m >> (5'(sb) + 5'(offset_bits_reg));
    assign shifted = addr_m >> offset_bits_reg;
    assign set_mask = (ADDR_BITS'(1) << sb) - ADDR_BITS'(1);
    assign set_in  = SET_W'(shifted & set_mask);

    logic                 st_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [SET_W-1:0]     set_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            st_reg  <= s_cmd;
            tag_reg <= tag_in;
            set_reg <= set_in;
        end
    end

    // Reset state of each set row is tracked by a per-set valid bit.
    logic [NUM_SETS-1:0] row_ok_reg;
    logic [SETROW_W-1:0] row_rd, row_wr;
    logic                rd_ok_reg;

    sactd_ram #(.WIDTH(SETROW_W), .DEPTH(NUM_SETS)) u_ram (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (set_reg),
        .wdata (row_wr),
        .re    (cmd.rd_en),
        .raddr (set_in),
        .rdata (row_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ok_reg <= '0;
        end else if (cmd.wr_en) begin
            row_ok_reg[set_reg] <= 1'b1;
        end
        if (cmd.rd_en) begin
            rd_ok_reg <= row_ok_reg[set_in];
        end
    end

    logic [ADDR_BITS-1:0] tg  [WAYS];
    logic                 vl  [WAYS];
    logic                 dt  [WAYS];
    logic [AGE_W-1:0]     ag  [WAYS];
    logic [NODES-1:0]     tree;

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            tg[i] = row_rd[i*LINE_W +: ADDR_BITS];
            vl[i] = rd_ok_reg & row_rd[i*LINE_W + ADDR_BITS];
            dt[i] = rd_ok_reg & row_rd[i*LINE_W + ADDR_BITS + 1];
            ag[i] = rd_ok_reg ? row_rd[i*LINE_W + ADDR_BITS + 2 +: AGE_W] : AGE_W'(i);
        end
        tree = rd_ok_reg ? row_rd[WAYS*LINE_W +: NODES] : '0;
    end

    logic             hit, found, ev, evd;
    logic [WAY_W-1:0] hw, iw, lv, pv, w;
    logic [NODES-1:0] tree_n;
    logic [AGE_W-1:0] old;

    always_comb begin
        int idx, ret, half, lo, span;
        logic lfound;
        hit = 1'b0; hw = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (vl[i] && tg[i] == tag_reg) begin
                hit = 1'b1; hw = WAY_W'(i);
            end
        end
        found = 1'b0; iw = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!vl[i]) begin
                found = 1'b1; iw = WAY_W'(i);
            end
        end
        lfound = 1'b0; lv = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (ag[i] == AGE_W'(WAYS - 1)) begin
                lfound = 1'b1; lv = WAY_W'(i);
            end
        end
        if (!lfound) begin
            lv = '0;
            for (int i = 1; i < WAYS; i++) begin
                if (ag[i] > ag[lv]) lv = WAY_W'(i);
            end
        end
        idx = 1; ret = 0; half = WAYS >> 1;
        for (int k = 0; k < WAY_W; k++) begin
            if (idx < WAYS) begin
                if (tree[idx-1]) begin
                    idx = idx * 2 + 1; ret = ret + half;
                end else begin
                    idx = idx * 2;
                end
            end
            half = half >> 1;
        end
        pv = (ret < WAYS) ? WAY_W'(ret) : WAY_W'(WAYS - 1);

        ev  = !hit && !found;
        w   = hit ? hw : (found ? iw : (policy_reg ? pv : lv));
        evd = ev && dt[w];

        tree_n = tree;
        lo = 0; span = WAYS; idx = 1;
        for (int k = 0; k < WAY_W; k++) begin
            if (span > 1 && idx < WAYS) begin
                half = span >> 1;
                if (int'(w) < lo + half) begin
                    tree_n[idx-1] = 1'b1; idx = idx * 2;
                end else begin
                    tree_n[idx-1] = 1'b0; idx = idx * 2 + 1; lo = lo + half;
                end
                span = half;
            end
        end
        old = ag[w];

        row_wr = '0;
        for (int i = 0; i < WAYS; i++) begin
            logic [AGE_W-1:0] na;
            na = ag[i];
            if (!policy_reg) begin
                if (WAY_W'(i) == w) na = '0;
                else if (ag[i] < old) na = ag[i] + AGE_W'(1);
            end
            row_wr[i*LINE_W +: ADDR_BITS] = (WAY_W'(i) == w && !hit) ? tag_reg : tg[i];
            row_wr[i*LINE_W + ADDR_BITS]  = vl[i] | (WAY_W'(i) == w);
            row_wr[i*LINE_W + ADDR_BITS + 1] = (WAY_W'(i) == w)
                ? (st_reg | (hit & dt[i])) : dt[i];
            row_wr[i*LINE_W + ADDR_BITS + 2 +: AGE_W] = na;
        end
        row_wr[WAYS*LINE_W +: NODES] = policy_reg ? tree_n : tree;
    end

    logic [31:0] hit_cnt_reg, miss_cnt_reg, dev_cnt_reg, cev_cnt_reg;
    logic [31:0] hit_cnt_next, miss_cnt_next, dev_cnt_next, cev_cnt_next;

    function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
        return (en && v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
    endfunction

    assign hit_cnt_next  = sat_inc(hit_cnt_reg, hit);
    assign miss_cnt_next = sat_inc(miss_cnt_reg, !hit);
    assign dev_cnt_next  = sat_inc(dev_cnt_reg, evd);
    assign cev_cnt_next  = sat_inc(cev_cnt_reg, ev && !evd);

    logic m_valid_reg;
    assign m_valid = m_valid_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            dev_cnt_reg  <= '0;
            cev_cnt_reg  <= '0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg  <= 1'b1;
                hit_cnt_reg  <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
                dev_cnt_reg  <= dev_cnt_next;
                cev_cnt_reg  <= cev_cnt_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_hit           <= hit;
            m_way           <= OUT_WAY_W'(w);
            m_evicted       <= ev;
            m_evicted_dirty <= evd;
        end
    end

    assign m_hit_total         = hit_cnt_reg;
    assign m_miss_total        = miss_cnt_reg;
    assign m_dirty_evict_total = dev_cnt_reg;
    assign m_clean_evict_total = cev_cnt_reg;
endmodule

FILE: design/set_assoc_cache_tag_directory_unit.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_cmd, s_addr
// m_        out        m_valid / m_ready   m_hit .. m_clean_evict_total
// cfg       in         cfg_we              cfg_index, cfg_wdata
//
// In each access, the set row is first read from the set RAM, then
// the updated row is written back and the result is registered.
// A new access is taken only after the previous one has written its row back,
// since the next access may read the row that this one writes back.
// Reset clears per-set valid bits in flip-flops; no clearing pass is needed.
// A stalled result holds off the next access only while it is still waiting.
module set_assoc_cache_tag_directory_unit import sactd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [47:0] s_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [1:0]  m_way,
    output logic        m_evicted,
    output logic        m_evicted_dirty,
    output logic [31:0] m_hit_total,
    output logic [31:0] m_miss_total,
    output logic [31:0] m_dirty_evict_total,
    output logic [31:0] m_clean_evict_total
);
    sactd_cmd_t  cmd;
    sactd_stat_t stat;

    sactd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .cmd(cmd)
    );

    sactd_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_cmd(s_cmd), .s_addr(s_addr), .m_ready(m_ready),
        .m_valid(m_valid), .m_hit(m_hit), .m_way(m_way), .m_evicted(m_evicted),
        .m_evicted_dirty(m_evicted_dirty), .m_hit_total(m_hit_total),
        .m_miss_total(m_miss_total), .m_dirty_evict_total(m_dirty_evict_total),
        .m_clean_evict_total(m_clean_evict_total), .cmd(cmd), .stat(stat)
    );
endmodule

FILE: design/sactd_checker.sv
module sactd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic        m_evicted,
    input logic        m_evicted_dirty,
    input logic [31:0] m_hit_total
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_total))
        else $error("result changed while stalled");
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("no result after transaction");
    a_no_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted two cycles in a row");
    a_ev_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> !m_hit)
        else $error("eviction on a hit");
    a_evd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted_dirty |-> m_evicted)
        else $error("dirty flag without eviction");
endmodule

bind set_assoc_cache_tag_directory_unit sactd_checker u_sactd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_evicted(m_evicted),
    .m_evicted_dirty(m_evicted_dirty), .m_hit_total(m_hit_total)
);

FILE: dv/tb_set_assoc_cache_tag_directory_unit.sv
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_directory_unit;
    import sactd_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [1:0]  way;
        logic        evicted;
        logic        evicted_dirty;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] dirty_evict_total;
        logic [31:0] clean_evict_total;
    } access_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_OFFSET;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = 1'b0;
    logic [47:0] s_addr = 48'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_hit;
    logic [1:0]  m_way;
    logic        m_evicted;
    logic        m_evicted_dirty;
    logic [31:0] m_hit_total;
    logic [31:0] m_miss_total;
    logic [31:0] m_dirty_evict_total;
    logic [31:0] m_clean_evict_total;

    set_assoc_cache_tag_directory_unit DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow directory state.
    logic [3:0]           sh_offset_bits;
    logic [2:0]           sh_set_bits;
    logic                 sh_policy;
    logic [47:0]          sh_tag   [NUM_SETS][WAYS];
    logic                 sh_valid [NUM_SETS][WAYS];
    logic                 sh_dirty [NUM_SETS][WAYS];
    int unsigned          sh_age   [NUM_SETS][WAYS];
    logic                 sh_tree  [NUM_SETS][NODES+1];
    logic [31:0]          sh_hits, sh_misses, sh_devict, sh_cevict;

    access_result_t pending_results[$];
    int error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned recv_hold = 0;
    longint unsigned cycle_count = 0;

    function automatic logic [31:0] sat_incr(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic access_result_t predict_access(logic is_store, logic [47:0] addr);
        access_result_t r;
        int unsigned sb, s, w, idx, lo, span, half, step, old;
        logic [47:0] tag;
        logic found;
        r = '0;
        sb = (sh_set_bits > MAX_SB) ? MAX_SB : sh_set_bits;
        tag = addr >> (sb + sh_offset_bits);
        s = (addr >> sh_offset_bits) & ((1 << sb) - 1);
        w = 0;
        found = 1'b0;
        for (int i = 0; i < WAYS; i++)
            if (!found && sh_valid[s][i] && sh_tag[s][i] == tag) begin
                w = i;
                found = 1'b1;
            end
        if (found) begin
            r.hit = 1'b1;
            sh_hits = sat_incr(sh_hits);
        end else begin
            for (int i = 0; i < WAYS; i++)
                if (!found && !sh_valid[s][i]) begin
                    w = i;
                    found = 1'b1;
                end
            if (!found) begin
                if (sh_policy) begin
                    idx = 1; w = 0; step = WAYS >> 1;
                    while (idx < WAYS) begin
                        if (sh_tree[s][idx]) begin
                            idx = idx * 2 + 1;
                            w += step;
                        end else begin
                            idx = idx * 2;
                        end
                        step >>= 1;
                    end
                    if (w >= WAYS) w = WAYS - 1;
                end else begin
                    w = 0;
                    found = 1'b0;
                    for (int i = 0; i < WAYS; i++)
                        if (!found && sh_age[s][i] == WAYS - 1) begin
                            w = i;
                            found = 1'b1;
                        end
                    if (!found)
                        for (int i = 1; i < WAYS; i++)
                            if (sh_age[s][i] > sh_age[s][w]) w = i;
                end
                r.evicted = 1'b1;
                r.evicted_dirty = sh_dirty[s][w];
                if (sh_dirty[s][w]) sh_devict = sat_incr(sh_devict);
                else sh_cevict = sat_incr(sh_cevict);
            end
            sh_valid[s][w] = 1'b1;
            sh_dirty[s][w] = 1'b0;
            sh_tag[s][w] = tag;
            sh_misses = sat_incr(sh_misses);
        end
        if (sh_policy) begin
            lo = 0; span = WAYS; idx = 1;
            while (span > 1 && idx < WAYS) begin
                half = span >> 1;
                if (w < lo + half) begin
                    sh_tree[s][idx] = 1'b1;
                    idx = idx * 2;
                end else begin
                    sh_tree[s][idx] = 1'b0;
                    idx = idx * 2 + 1;
                    lo += half;
                end
                span = half;
            end
        end else begin
            old = sh_age[s][w];
            sh_age[s][w] = 0;
            for (int i = 0; i < WAYS; i++)
                if (i != w && sh_age[s][i] < old) sh_age[s][i]++;
        end
        if (is_store) sh_dirty[s][w] = 1'b1;
        r.way = w[1:0];
        r.hit_total = sh_hits;
        r.miss_total = sh_misses;
        r.dirty_evict_total = sh_devict;
        r.clean_evict_total = sh_cevict;
        return r;
    endfunction

    task automatic send_access(logic is_store, logic [47:0] addr);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= is_store;
        s_addr <= addr;
        pending_results.push_back(predict_access(is_store, addr));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_OFFSET: sh_offset_bits = val;
            CFG_SETB:   sh_set_bits = val[2:0];
            default:    sh_policy = val[0];
        endcase
    endtask

    task automatic set_config(logic [3:0] ob, logic [2:0] sb, logic pol);
        wait_drained();
        write_reg(CFG_OFFSET, ob);
        write_reg(CFG_SETB, {1'b0, sb});
        write_reg(CFG_POLICY, {3'b0, pol});
        cfg_we <= 1'b0;
    endtask

    // Addresses mostly drawn from a small pool of tags so that sets fill and evict.
    function automatic logic [47:0] pool_addr();
        logic [47:0] a;
        int unsigned sb;
        sb = (sh_set_bits > MAX_SB) ? MAX_SB : sh_set_bits;
        a = 48'({$urandom, $urandom});
        if ($urandom_range(9) != 0) begin
            a = a & ((48'd1 << (sb + sh_offset_bits)) - 1);
            a = a & ~(48'((1 << sb) - 1 - ($urandom_range(1) << (sb > 0))) << sh_offset_bits);
            a = a | (48'($urandom_range(6)) << (sb + sh_offset_bits));
            if ($urandom_range(7) == 0) a[47:44] = 4'hF;
        end
        return a;
    endfunction

    task automatic test_directed();
        // Same set: fill four ways, hit, evict clean and dirty lines.
        for (int t = 0; t < 6; t++)
            send_access(t[0], 48'(t) << 12);
        send_access(1'b0, 48'd2 << 12);
        send_access(1'b1, 48'hFFFF_FFFF_FFFF);
        send_access(1'b0, 48'h0000_0000_003F);
        send_access(1'b1, 48'h8000_0000_0000);
        set_config(4'd12, 3'd7, 1'b1);
        for (int t = 0; t < 7; t++)
            send_access(t[0], 48'(t) << 18);
        send_access(1'b0, 48'hFFFF_FFFF_FFFF);
        set_config(4'd0, 3'd0, 1'b0);
        for (int t = 0; t < 6; t++)
            send_access(1'b1, 48'(t));
    endtask

    // The other policy's state goes stale; switching must still work.
    task automatic write_policy_midrun();
        wait_drained();
        write_reg(CFG_POLICY, {3'b0, ~sh_policy});
        cfg_we <= 1'b0;
    endtask

    task automatic test_random(int n, logic [3:0] ob, logic [2:0] sb, logic pol);
        set_config(ob, sb, pol);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) write_policy_midrun();
            send_access($urandom_range(1), pool_addr());
        end
    endtask

    task automatic test_backpressure();
        set_config(4'd4, 3'd2, 1'b0);
        recv_hold = 60;
        for (int i = 0; i < 20; i++)
            send_access($urandom_range(1), pool_addr());
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_hold != 0) begin
            recv_hold <= recv_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
        end
        if (aresetn && m_valid && m_ready) begin
            access_result_t got, want;
            got = {m_hit, m_way, m_evicted, m_evicted_dirty, m_hit_total,
                   m_miss_total, m_dirty_evict_total, m_clean_evict_total};
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected transaction: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        sh_offset_bits = 4'd6;
        sh_set_bits = 3'd6;
        sh_policy = 1'b0;
        sh_hits = '0; sh_misses = '0; sh_devict = '0; sh_cevict = '0;
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                sh_tag[s][w] = '0;
                sh_valid[s][w] = 1'b0;
                sh_dirty[s][w] = 1'b0;
                sh_age[s][w] = w;
            end
            for (int n = 0; n <= NODES; n++) sh_tree[s][n] = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_idle_pct = 20; recv_idle_pct = 81;
        test_random(260, 4'd6, 3'd1, 1'b0);
        test_backpressure();
        send_idle_pct = 81; recv_idle_pct = 20;
        test_random(260, 4'd3, 3'd0, 1'b1);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(260, 4'd12, 3'd6, 1'b0);
        wait_drained();
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
